/* hdl/baro_pressure_temp_compensation_core_assert.svh */
// Assertion macros for the barometric compensation core.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define BPC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hdl/bpc_pkg.sv */
// Package with types, constants and shared functions of the compensation core.
`default_nettype none
package bpc_pkg;
   localparam int unsigned DivLatency = 33;
   localparam int unsigned DefaultDivLatency = DivLatency;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [27:0] temperature_tenths;
      logic signed [31:0] pressure_pa;
      logic               divide_error;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_AC123 = 2'd0,
      REG_AC456 = 2'd1,
      REG_B12   = 2'd2,
      REG_MCMD  = 2'd3
   } csr_index_type;

   // Calibration words unpacked to 32-bit signed values.
   typedef struct packed {
      logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   } cal_type;

   // Signed division truncating toward zero by a power of two.
   function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                    input int unsigned sh);
      logic signed [31:0] bias;
      bias = a[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
      return (a + bias) >>> sh;
   endfunction
endpackage
`default_nettype wire

/* hdl/bpc_div.sv */
// Pipelined restoring divider, unsigned 32 by 32, one quotient bit per stage.
`default_nettype none
module bpc_div
   import bpc_pkg::*;
#(
   parameter int unsigned TagWidth = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [31:0]         in_num,
   input  wire logic [31:0]         in_den,
   input  wire logic [TagWidth-1:0] in_tag,
   output logic                     out_valid,
   output logic [31:0]              out_quo,
   output logic [TagWidth-1:0]      out_tag
);
   logic                vld_ff [0:32];
   logic [31:0]         rem_ff [0:32];
   logic [31:0]         quo_ff [0:32];
   logic [31:0]         den_ff [0:32];
   logic [TagWidth-1:0] tag_ff [0:32];

   // Stage zero registers the operands.
   always_ff @(posedge clock) begin
      vld_ff[0] <= reset ? 1'b0 : in_valid;
      rem_ff[0] <= '0;
      quo_ff[0] <= in_num;
      den_ff[0] <= in_den;
      tag_ff[0] <= in_tag;
   end

   // Each stage shifts in one numerator bit and resolves one quotient bit.
   for (genvar s = 0; s < 32; s++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] shifted;
      assign shifted = {rem_ff[s], quo_ff[s][31]};
      assign trial   = shifted - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         vld_ff[s+1] <= reset ? 1'b0 : vld_ff[s];
         if (!trial[32]) begin
            rem_ff[s+1] <= trial[31:0];
         end else begin
            rem_ff[s+1] <= shifted[31:0];
         end
         quo_ff[s+1] <= {quo_ff[s][30:0], ~trial[32]};
         den_ff[s+1] <= den_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = vld_ff[32];
   assign out_quo   = quo_ff[32];
   assign out_tag   = tag_ff[32];
endmodule
`default_nettype wire

/* hdl/bpc_temp.sv */
// Temperature stages: X1, divisor, signed division of MC*2048 and B5.
`default_nettype none
module bpc_temp
   import bpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire req_type            in_req,
   input  wire cal_type            cal,
   output logic                    out_valid,
   output logic signed [31:0]      out_b5,
   output logic [15:0]             out_up,
   output logic                    out_err
);
   localparam int unsigned TagW = 16 + 32 + 1 + 1;

   logic               v1_ff;
   logic signed [31:0] x1_ff, prod_in;
   logic [15:0]        up1_ff;
   logic               v2_ff;
   logic signed [31:0] x1b_ff, num_ff, den_ff;
   logic [15:0]        up2_ff;
   logic signed [31:0] x1_in;
   logic [31:0]        num_abs, den_abs;
   logic               neg;
   logic               dv;
   logic [31:0]        dq;
   logic [TagW-1:0]    dtag;
   logic signed [31:0] q;
   logic signed [31:0] xb;

   // Stage one: (UT - AC6) * AC5.
   assign prod_in = ($signed({16'd0, in_req.raw_temperature}) - cal.ac6) * cal.ac5;
   always_ff @(posedge clock) begin
      v1_ff  <= reset ? 1'b0 : in_valid;
      x1_ff  <= prod_in;
      up1_ff <= in_req.raw_pressure[23:8];
   end

   // Stage two: X1, divisor and numerator MC*2048.
   assign x1_in = sdiv_pow2(x1_ff, 15);
   always_ff @(posedge clock) begin
      v2_ff   <= reset ? 1'b0 : v1_ff;
      x1b_ff  <= x1_in;
      num_ff  <= cal.mc <<< 11;
      den_ff  <= x1_in + cal.md;
      up2_ff  <= up1_ff;
   end

   // Signed division through the unsigned divider with sign correction.
   assign num_abs = num_ff[31] ? 32'(-num_ff) : 32'(num_ff);
   assign den_abs = den_ff[31] ? 32'(-den_ff) : 32'(den_ff);
   assign neg     = num_ff[31] ^ den_ff[31];

   bpc_div #(.TagWidth(TagW)) u_div (
      .clock(clock), .reset(reset), .in_valid(v2_ff),
      .in_num(num_abs), .in_den(den_abs),
      .in_tag({up2_ff, x1b_ff, neg, (den_ff == 32'sd0)}),
      .out_valid(dv), .out_quo(dq), .out_tag(dtag)
   );

   assign xb = $signed(dtag[33:2]);
   assign q  = dtag[1] ? -$signed(dq) : $signed(dq);

   // Final stage: B5 = X1 + X2.
   always_ff @(posedge clock) begin
      out_valid <= reset ? 1'b0 : dv;
      out_b5    <= xb + q;
      out_up    <= dtag[49:34];
      out_err   <= dtag[0];
   end
endmodule
`default_nettype wire

/* hdl/bpc_press.sv */
// Pressure stages: T, B6, B3, B4, B7, the unsigned quotient and the final correction.
`default_nettype none
module bpc_press
   import bpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic signed [31:0] in_b5,
   input  wire logic [15:0]   in_up,
   input  wire logic          in_err,
   input  wire cal_type       cal,
   output logic               out_valid,
   output rsp_type            out_rsp
);
   localparam int unsigned TagW = 28 + 1 + 1;

   // Stage A: B6 and T.
   logic               va_ff, erra_ff;
   logic signed [31:0] b6a_ff;
   logic signed [27:0] ta_ff;
   logic [15:0]        upa_ff;
   always_ff @(posedge clock) begin
      va_ff   <= reset ? 1'b0 : in_valid;
      b6a_ff  <= in_b5 - 32'sd4000;
      ta_ff   <= 28'(sdiv_pow2(in_b5 + 32'sd8, 4));
      upa_ff  <= in_up;
      erra_ff <= in_err;
   end

   // Stage B: B6*B6, AC2*B6, AC3*B6.
   logic               vb_ff, errb_ff;
   logic signed [31:0] sqp_ff, ac2p_ff, ac3p_ff;
   logic signed [27:0] tb_ff;
   logic [15:0]        upb_ff;
   always_ff @(posedge clock) begin
      vb_ff   <= reset ? 1'b0 : va_ff;
      sqp_ff  <= b6a_ff * b6a_ff;
      ac2p_ff <= cal.ac2 * b6a_ff;
      ac3p_ff <= cal.ac3 * b6a_ff;
      tb_ff   <= ta_ff;
      upb_ff  <= upa_ff;
      errb_ff <= erra_ff;
   end

   // Stage C: B2*sq and B1*sq.
   logic               vc_ff, errc_ff;
   logic signed [31:0] b2p_ff, b1p_ff, x2c_ff, x1c_ff, sq_c;
   logic signed [27:0] tc_ff;
   logic [15:0]        upc_ff;
   assign sq_c = sdiv_pow2(sqp_ff, 12);
   always_ff @(posedge clock) begin
      vc_ff   <= reset ? 1'b0 : vb_ff;
      b2p_ff  <= cal.b2 * sq_c;
      b1p_ff  <= cal.b1 * sq_c;
      x2c_ff  <= sdiv_pow2(ac2p_ff, 11);
      x1c_ff  <= sdiv_pow2(ac3p_ff, 13);
      tc_ff   <= tb_ff;
      upc_ff  <= upb_ff;
      errc_ff <= errb_ff;
   end

   // Stage D: B3 and the X3 + 32768 term.
   logic               vd_ff, errd_ff;
   logic signed [31:0] b3d_ff, x3d_ff, b3_in, x3_in;
   logic signed [27:0] td_ff;
   logic [15:0]        upd_ff;
   assign b3_in = sdiv_pow2((cal.ac1 <<< 2) + sdiv_pow2(b2p_ff, 11) + x2c_ff + 32'sd2, 2);
   assign x3_in = sdiv_pow2(x1c_ff + sdiv_pow2(b1p_ff, 16) + 32'sd2, 2) + 32'sd32768;
   always_ff @(posedge clock) begin
      vd_ff   <= reset ? 1'b0 : vc_ff;
      b3d_ff  <= b3_in;
      x3d_ff  <= x3_in;
      td_ff   <= tc_ff;
      upd_ff  <= upc_ff;
      errd_ff <= errc_ff;
   end

   // Stage E: B4 product and B7 product.
   logic               ve_ff, erre_ff;
   logic [31:0]        b4p_ff, b7_ff;
   logic signed [27:0] te_ff;
   always_ff @(posedge clock) begin
      ve_ff   <= reset ? 1'b0 : vd_ff;
      b4p_ff  <= 32'(cal.ac4) * 32'(x3d_ff);
      b7_ff   <= ({16'd0, upd_ff} - 32'(b3d_ff)) * 32'd50000;
      te_ff   <= td_ff;
      erre_ff <= errd_ff;
   end

   // Stage F: B4 and the divider operands.
   logic               vf_ff, errf_ff, hif_ff;
   logic [31:0]        b4f_ff, numf_ff;
   logic signed [27:0] tf_ff;
   always_ff @(posedge clock) begin
      vf_ff   <= reset ? 1'b0 : ve_ff;
      b4f_ff  <= {15'd0, b4p_ff[31:15]};
      hif_ff  <= b7_ff[31];
      numf_ff <= b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
      tf_ff   <= te_ff;
      errf_ff <= erre_ff;
   end

   logic            dv;
   logic [31:0]     dq;
   logic [TagW-1:0] dtag;
   bpc_div #(.TagWidth(TagW)) u_div (
      .clock(clock), .reset(reset), .in_valid(vf_ff),
      .in_num(numf_ff), .in_den(b4f_ff),
      .in_tag({tf_ff, hif_ff, errf_ff | (b4f_ff == 32'd0)}),
      .out_valid(dv), .out_quo(dq), .out_tag(dtag)
   );

   // Stage G: p and the correction products.
   logic               vg_ff, errg_ff;
   logic signed [31:0] pg_ff, x1g_ff, x2g_ff, p_in, ps;
   logic signed [27:0] tg_ff;
   assign p_in = dtag[1] ? $signed({dq[30:0], 1'b0}) : $signed(dq);
   assign ps   = sdiv_pow2(p_in, 8);
   always_ff @(posedge clock) begin
      vg_ff   <= reset ? 1'b0 : dv;
      pg_ff   <= p_in;
      x1g_ff  <= ps * ps;
      x2g_ff  <= -32'sd7357 * p_in;
      tg_ff   <= $signed(dtag[29:2]);
      errg_ff <= dtag[0];
   end

   // Stage H: X1 * 3038.
   logic               vh_ff, errh_ff;
   logic signed [31:0] ph_ff, x1h_ff, x2h_ff;
   logic signed [27:0] th_ff;
   always_ff @(posedge clock) begin
      vh_ff   <= reset ? 1'b0 : vg_ff;
      ph_ff   <= pg_ff;
      x1h_ff  <= x1g_ff * 32'sd3038;
      x2h_ff  <= sdiv_pow2(x2g_ff, 16);
      th_ff   <= tg_ff;
      errh_ff <= errg_ff;
   end

   // Output register: final sum; pressure and temperature zeroed on a divide error.
   logic signed [31:0] pfin;
   assign pfin = ph_ff + sdiv_pow2(sdiv_pow2(x1h_ff, 16) + x2h_ff + 32'sd3791, 4);
   always_ff @(posedge clock) begin
      out_valid <= reset ? 1'b0 : vh_ff;
      out_rsp.temperature_tenths <= errh_ff ? 28'sd0 : th_ff;
      out_rsp.pressure_pa        <= errh_ff ? 32'sd0 : pfin;
      out_rsp.divide_error       <= errh_ff;
   end
endmodule
`default_nettype wire

/* hdl/baro_pressure_temp_compensation_core.sv */
// Top level of the barometric temperature and pressure compensation core.
// A request is taken in every cycle (busy stays low); each result passes through
// 36 temperature stages (2 + a 33-stage divider + 1), then 42 pressure stages
// (6 + a second 33-stage divider + 3), with two bit-per-stage dividers.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none
`include "baro_pressure_temp_compensation_core_assert.svh"
module baro_pressure_temp_compensation_core
   import bpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data
);
   logic [47:0] ac123_ff, ac456_ff;
   logic [31:0] b12_ff, mcmd_ff;
   cal_type     cal;

   // Calibration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ac123_ff <= '0; ac456_ff <= '0; b12_ff <= '0; mcmd_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_AC123: ac123_ff <= csr_data;
            REG_AC456: ac456_ff <= csr_data;
            REG_B12:   b12_ff   <= csr_data[31:0];
            REG_MCMD:  mcmd_ff  <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // Unpack calibration words.
   always_comb begin
      cal.ac1 = 32'(signed'(ac123_ff[47:32]));
      cal.ac2 = 32'(signed'(ac123_ff[31:16]));
      cal.ac3 = 32'(signed'(ac123_ff[15:0]));
      cal.ac4 = {16'd0, ac456_ff[47:32]};
      cal.ac5 = {16'd0, ac456_ff[31:16]};
      cal.ac6 = {16'd0, ac456_ff[15:0]};
      cal.b1  = 32'(signed'(b12_ff[31:16]));
      cal.b2  = 32'(signed'(b12_ff[15:0]));
      cal.mc  = 32'(signed'(mcmd_ff[31:16]));
      cal.md  = 32'(signed'(mcmd_ff[15:0]));
   end

   assign busy = 1'b0;

   logic               t_valid, t_err;
   logic signed [31:0] t_b5;
   logic [15:0]        t_up;

   bpc_temp u_temp (
      .clock(clock), .reset(reset), .in_valid(start & ~busy), .in_req(req_data),
      .cal(cal), .out_valid(t_valid), .out_b5(t_b5), .out_up(t_up), .out_err(t_err)
   );

   bpc_press u_press (
      .clock(clock), .reset(reset), .in_valid(t_valid), .in_b5(t_b5),
      .in_up(t_up), .in_err(t_err), .cal(cal),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

   // Checks on the result path.
   `BPC_ASSERT_IMPL(a_err_zero, clock, reset,
      rsp_valid && rsp_data.divide_error |-> rsp_data.pressure_pa == 32'sd0,
      "divide error with nonzero pressure")
   `BPC_ASSERT_IMPL(a_err_zero_t, clock, reset,
      rsp_valid && rsp_data.divide_error |-> rsp_data.temperature_tenths == 28'sd0,
      "divide error with nonzero temperature")
   `BPC_ASSERT_NORST(a_reset_quiet, clock, reset |=> !rsp_valid,
      "result strobe right after reset")
endmodule
`default_nettype wire
